// ----- design/msm_pkg.sv -----
`timescale 1ns / 1ps

package msm_pkg;

    // Result kinds as they appear on the output channel.
    typedef enum logic [1:0] {
        KIND_MSG   = 2'd0,
        KIND_DELAY = 2'd1,
        KIND_END   = 2'd2,
        KIND_BAD   = 2'd3
    } t_kind;

    // What the back end does with one queue entry.
    typedef enum logic {
        OP_RESULT = 1'b0,
        OP_VOLS   = 1'b1
    } t_op;

    // One classified byte, as handed from the front end to the back end.
    typedef struct packed {
        t_op         op;
        t_kind       kind;
        logic [7:0]  status;
        logic [6:0]  data_one;
        logic [11:0] data_two;
        logic        scale;
        logic [31:0] ticks;
        logic        add_end;
    } t_cmd;

    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [7:0] ST_NOTE_OFF = 8'h80;
    localparam logic [7:0] ST_NOTE_ON  = 8'h90;
    localparam logic [7:0] ST_CTRL     = 8'hb0;
    localparam logic [7:0] ST_PROGRAM  = 8'hc0;
    localparam logic [7:0] ST_BEND     = 8'he0;

    localparam logic [6:0] CC_VOLUME    = 7'd7;
    localparam logic [6:0] NOTE_OFF_VEL = 7'd64;

    // Reciprocal of 15 scaled by 2^15; exact for products below 4096.
    localparam logic [11:0] DIV15_MUL   = 12'd2185;
    localparam int          DIV15_SHIFT = 15;

    localparam logic [6:0] VEL_RESET = 7'd127;

    function automatic logic [3:0] chan_map(input logic [3:0] ch);
        logic [3:0] r;
        case (ch)
            4'd15:   r = 4'd9;
            4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14: r = ch + 4'd1;
            default: r = ch;
        endcase
        return r;
    endfunction

    function automatic logic [6:0] ctrl_map(input logic [7:0] idx);
        logic [6:0] r;
        case (idx)
            8'd2:    r = 7'd1;
            8'd3:    r = 7'd7;
            8'd4:    r = 7'd10;
            8'd5:    r = 7'd11;
            8'd6:    r = 7'd91;
            8'd7:    r = 7'd93;
            8'd8:    r = 7'd64;
            8'd9:    r = 7'd67;
            8'd10:   r = 7'd120;
            8'd11:   r = 7'd123;
            8'd12:   r = 7'd126;
            8'd13:   r = 7'd127;
            8'd14:   r = 7'd121;
            default: r = 7'd0;
        endcase
        return r;
    endfunction

    // 100 * volume / 15, rounded down.
    function automatic logic [6:0] vol_level(input logic [3:0] vol);
        logic [6:0] r;
        case (vol)
            4'd1:    r = 7'd6;
            4'd2:    r = 7'd13;
            4'd3:    r = 7'd20;
            4'd4:    r = 7'd26;
            4'd5:    r = 7'd33;
            4'd6:    r = 7'd40;
            4'd7:    r = 7'd46;
            4'd8:    r = 7'd53;
            4'd9:    r = 7'd60;
            4'd10:   r = 7'd66;
            4'd11:   r = 7'd73;
            4'd12:   r = 7'd80;
            4'd13:   r = 7'd86;
            4'd14:   r = 7'd93;
            4'd15:   r = 7'd100;
            default: r = 7'd0;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] magic_byte(input logic [1:0] idx);
        logic [7:0] r;
        case (idx)
            2'd0:    r = 8'h4d;
            2'd1:    r = 8'h55;
            2'd2:    r = 8'h53;
            default: r = 8'h1a;
        endcase
        return r;
    endfunction

endpackage

// ----- design/msm_front.sv -----
`timescale 1ns / 1ps

module msm_front
    import msm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_data_byte,
    input  logic       i_song_start,
    input  logic [3:0] i_music_volume,
    input  logic       i_full,
    output logic       o_stall,
    output logic       o_push,
    output t_cmd       o_cmd
);

    typedef enum logic [7:0] {
        PH_HEADER = 8'b0000_0001,
        PH_SKIP   = 8'b0000_0010,
        PH_HEAD   = 8'b0000_0100,
        PH_DATA   = 8'b0000_1000,
        PH_VEL    = 8'b0001_0000,
        PH_VALUE  = 8'b0010_0000,
        PH_DELAY  = 8'b0100_0000,
        PH_DONE   = 8'b1000_0000
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [16:0] r_pos, n_pos;
    logic [15:0] r_start, n_start;
    logic [16:0] r_end, n_end;
    logic [2:0]  r_etype, n_etype;
    logic [3:0]  r_echan, n_echan;
    logic        r_elast, n_elast;
    logic [7:0]  r_pend, n_pend;
    logic [6:0]  r_vel [16];
    logic [6:0]  n_vel [16];
    logic [31:0] r_dacc, n_dacc;
    logic        r_magic, n_magic;

    logic        w_acc;
    logic [7:0]  w_mul_a;
    logic [11:0] w_prod;
    logic [7:0]  w_mch;

    assign w_acc   = i_valid && !i_full;
    assign o_stall = i_full;
    assign w_mch   = {4'd0, chan_map(r_echan)};
    assign w_prod  = {4'd0, w_mul_a} * {8'd0, i_music_volume};

    always_comb begin
        case (r_phase)
            PH_DATA: w_mul_a = {1'b0, r_vel[r_echan]};
            PH_VEL:  w_mul_a = {1'b0, i_data_byte[6:0]};
            default: w_mul_a = i_data_byte;
        endcase
    end

    always_comb begin
        t_phase      ph;
        logic [16:0] pos;
        logic        magic;
        logic        main;
        logic        chk_end;
        logic        last_now;
        logic        evt_done;
        logic [15:0] startf;
        logic [16:0] endf;
        logic [16:0] pos1;
        logic [7:0]  b;

        b       = i_data_byte;
        ph      = i_song_start ? PH_HEADER : r_phase;
        pos     = i_song_start ? 17'd0 : r_pos;
        magic   = i_song_start ? 1'b1 : r_magic;

        n_phase = r_phase;
        n_pos   = r_pos;
        n_start = r_start;
        n_end   = r_end;
        n_etype = r_etype;
        n_echan = r_echan;
        n_elast = r_elast;
        n_pend  = r_pend;
        n_vel   = r_vel;
        n_dacc  = r_dacc;
        n_magic = r_magic;

        if (i_song_start) begin
            n_phase = PH_HEADER;
            n_pos   = 17'd0;
            n_start = 16'd0;
            n_end   = 17'd0;
            n_etype = 3'd0;
            n_echan = 4'd0;
            n_elast = 1'b0;
            n_pend  = 8'd0;
            n_dacc  = 32'd0;
            n_magic = 1'b1;
            for (int i = 0; i < 16; i++) begin
                n_vel[i] = VEL_RESET;
            end
        end

        o_cmd          = '0;
        o_cmd.op       = OP_RESULT;
        o_cmd.kind     = KIND_MSG;
        o_push         = 1'b0;
        main           = 1'b0;
        chk_end        = 1'b0;
        last_now       = r_elast;
        evt_done       = 1'b0;
        startf         = {b, r_start[7:0]};
        endf           = r_end + {1'b0, startf};
        pos1           = pos + 17'd1;

        case (ph)
            PH_HEADER: begin
                n_pos = pos1;
                if (pos < 17'd4 && b != magic_byte(pos[1:0])) begin
                    n_magic = 1'b0;
                end
                if (pos == 17'd4) begin
                    n_end = {9'd0, b};
                end
                if (pos == 17'd5) begin
                    n_end = {1'b0, b, r_end[7:0]};
                end
                if (pos == 17'd6) begin
                    n_start = {8'd0, b};
                end
                if (pos == 17'd7) begin
                    n_start = startf;
                    n_end   = endf;
                    o_push  = 1'b1;
                    if (!magic || endf < 17'd16 || {1'b0, startf} >= endf
                        || startf < 16'd8) begin
                        o_cmd.kind = KIND_BAD;
                        n_phase    = PH_DONE;
                        n_pos      = pos;
                    end else begin
                        o_cmd.op = OP_VOLS;
                        n_phase  = (startf == 16'd8) ? PH_HEAD : PH_SKIP;
                    end
                end
            end
            PH_SKIP: begin
                chk_end = 1'b1;
                if (pos1 >= {1'b0, r_start}) begin
                    n_phase = PH_HEAD;
                end
            end
            PH_HEAD: begin
                n_elast  = b[7];
                n_etype  = b[6:4];
                n_echan  = b[3:0];
                last_now = b[7];
                if (b[6:4] == 3'd5) begin
                    o_push     = 1'b1;
                    o_cmd.kind = KIND_END;
                    n_phase    = PH_DONE;
                end else begin
                    chk_end = 1'b1;
                    if (b[6:4] >= 3'd6) begin
                        evt_done = 1'b1;
                    end else begin
                        n_phase = PH_DATA;
                    end
                end
            end
            PH_DATA: begin
                chk_end = 1'b1;
                n_pend  = b;
                case (r_etype)
                    3'd0: begin
                        main           = 1'b1;
                        o_cmd.status   = ST_NOTE_OFF | w_mch;
                        o_cmd.data_one = b[6:0];
                        o_cmd.data_two = {5'd0, NOTE_OFF_VEL};
                        evt_done       = 1'b1;
                    end
                    3'd1: begin
                        if (b[7]) begin
                            n_phase = PH_VEL;
                        end else begin
                            main           = 1'b1;
                            o_cmd.status   = ST_NOTE_ON | w_mch;
                            o_cmd.data_one = b[6:0];
                            o_cmd.data_two = w_prod;
                            o_cmd.scale    = 1'b1;
                            evt_done       = 1'b1;
                        end
                    end
                    3'd2: begin
                        main           = 1'b1;
                        o_cmd.status   = ST_BEND | w_mch;
                        o_cmd.data_one = {b[0], 6'd0};
                        o_cmd.data_two = {5'd0, b[7:1]};
                        evt_done       = 1'b1;
                    end
                    3'd3: begin
                        if (b >= 8'd10 && b <= 8'd14) begin
                            main           = 1'b1;
                            o_cmd.status   = ST_CTRL | w_mch;
                            o_cmd.data_one = ctrl_map(b);
                        end
                        evt_done = 1'b1;
                    end
                    default: begin
                        n_phase = PH_VALUE;
                    end
                endcase
            end
            PH_VEL: begin
                chk_end          = 1'b1;
                n_vel[r_echan]   = b[6:0];
                main             = 1'b1;
                o_cmd.status     = ST_NOTE_ON | w_mch;
                o_cmd.data_one   = r_pend[6:0];
                o_cmd.data_two   = w_prod;
                o_cmd.scale      = 1'b1;
                evt_done         = 1'b1;
            end
            PH_VALUE: begin
                chk_end  = 1'b1;
                evt_done = 1'b1;
                if (r_pend == 8'd0) begin
                    main           = 1'b1;
                    o_cmd.status   = ST_PROGRAM | w_mch;
                    o_cmd.data_one = b[6:0];
                end else if (r_pend < 8'd10) begin
                    main           = 1'b1;
                    o_cmd.status   = ST_CTRL | w_mch;
                    o_cmd.data_one = ctrl_map(r_pend);
                    if (r_pend == 8'd3) begin
                        o_cmd.data_two = w_prod;
                        o_cmd.scale    = 1'b1;
                    end else begin
                        o_cmd.data_two = {4'd0, b};
                    end
                end
            end
            PH_DELAY: begin
                chk_end = 1'b1;
                n_dacc  = {r_dacc[24:0], b[6:0]};
                if (!b[7]) begin
                    main        = 1'b1;
                    o_cmd.kind  = KIND_DELAY;
                    o_cmd.ticks = {r_dacc[24:0], b[6:0]};
                    n_phase     = PH_HEAD;
                end
            end
            default: begin
                n_phase = r_phase;
            end
        endcase

        if (evt_done) begin
            if (last_now) begin
                n_dacc  = 32'd0;
                n_phase = PH_DELAY;
            end else begin
                n_phase = PH_HEAD;
            end
        end

        if (chk_end) begin
            n_pos = pos1;
            if (pos1 >= r_end && n_phase != PH_DONE) begin
                n_phase = PH_DONE;
                if (main) begin
                    o_cmd.add_end = 1'b1;
                end else begin
                    o_cmd      = '0;
                    o_cmd.op   = OP_RESULT;
                    o_cmd.kind = KIND_END;
                end
                o_push = 1'b1;
            end
        end
        if (main) begin
            o_push = 1'b1;
        end
        o_push = o_push && w_acc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_pos   <= '0;
            r_start <= '0;
            r_end   <= '0;
            r_etype <= '0;
            r_echan <= '0;
            r_elast <= 1'b0;
            r_pend  <= '0;
            r_dacc  <= '0;
            r_magic <= 1'b1;
            for (int i = 0; i < 16; i++) begin
                r_vel[i] <= VEL_RESET;
            end
        end else if (w_acc) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_start <= n_start;
            r_end   <= n_end;
            r_etype <= n_etype;
            r_echan <= n_echan;
            r_elast <= n_elast;
            r_pend  <= n_pend;
            r_dacc  <= n_dacc;
            r_magic <= n_magic;
            r_vel   <= n_vel;
        end
    end

endmodule

// ----- design/msm_queue.sv -----
`timescale 1ns / 1ps

module msm_queue
    import msm_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_full,
    output logic o_nonempty,
    output t_cmd o_cmd
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [AW-1:0] r_wr, n_wr;
    logic [AW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_cnt, n_cnt;

    assign o_full     = (r_cnt == CW'(DEPTH));
    assign o_nonempty = (r_cnt != '0);
    assign o_cmd      = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
        end
        if (i_pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

// ----- design/msm_back.sv -----
`timescale 1ns / 1ps

module msm_back
    import msm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_nonempty,
    input  t_cmd        i_q_cmd,
    input  logic [3:0]  i_music_volume,
    input  logic        i_stall,
    output logic        o_pop,
    output logic        o_valid,
    output logic [1:0]  o_result_kind,
    output logic [7:0]  o_midi_status,
    output logic [6:0]  o_midi_data_one,
    output logic [6:0]  o_midi_data_two,
    output logic [31:0] o_delay_ticks,
    output logic        o_last_of_run
);

    logic        r_valid;
    logic [3:0]  r_cnt, n_cnt;
    logic [1:0]  r_kind, n_kind;
    logic [7:0]  r_status, n_status;
    logic [6:0]  r_d1, n_d1;
    logic [6:0]  r_d2, n_d2;
    logic [31:0] r_ticks, n_ticks;
    logic        r_last, n_last;

    logic        w_load;
    logic        w_done;
    logic [23:0] w_quot;

    assign w_load = i_q_nonempty && (!r_valid || !i_stall);
    assign o_pop  = w_load && w_done;
    assign w_quot = {12'd0, i_q_cmd.data_two} * {12'd0, DIV15_MUL};

    always_comb begin
        n_kind   = KIND_MSG;
        n_status = '0;
        n_d1     = '0;
        n_d2     = '0;
        n_ticks  = '0;
        n_last   = 1'b1;
        w_done   = 1'b1;
        if (i_q_cmd.op == OP_VOLS) begin
            n_status = ST_CTRL | {4'd0, chan_map(r_cnt)};
            n_d1     = CC_VOLUME;
            n_d2     = vol_level(i_music_volume);
            n_last   = (r_cnt == 4'hf);
            w_done   = n_last;
        end else if (r_cnt == 4'd0) begin
            n_kind   = i_q_cmd.kind;
            n_status = i_q_cmd.status;
            n_d1     = i_q_cmd.data_one;
            n_d2     = i_q_cmd.scale ? w_quot[DIV15_SHIFT +: 7] : i_q_cmd.data_two[6:0];
            n_ticks  = i_q_cmd.ticks;
            n_last   = !i_q_cmd.add_end;
            w_done   = !i_q_cmd.add_end;
        end else begin
            n_kind = KIND_END;
        end
        n_cnt = w_done ? 4'd0 : r_cnt + 4'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_cnt   <= '0;
        end else if (w_load) begin
            r_valid <= 1'b1;
            r_cnt   <= n_cnt;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_kind   <= n_kind;
            r_status <= n_status;
            r_d1     <= n_d1;
            r_d2     <= n_d2;
            r_ticks  <= n_ticks;
            r_last   <= n_last;
        end
    end

    assign o_valid         = r_valid;
    assign o_result_kind   = r_kind;
    assign o_midi_status   = r_status;
    assign o_midi_data_one = r_d1;
    assign o_midi_data_two = r_d2;
    assign o_delay_ticks   = r_ticks;
    assign o_last_of_run   = r_last;

endmodule

// ----- design/mus_score_to_midi_converter.sv -----
`timescale 1ns / 1ps

// Channel    Direction  Handshake              Payload
// input      in         i_valid / o_stall      i_data_byte, i_song_start
// output     out        o_valid / i_stall      o_result_kind .. o_last_of_run
// config     in         psel/penable/pready    paddr, pwdata, pwrite, prdata
//
// A byte is taken in every cycle while the command queue has room; the parser
// handles it in that cycle and writes at most one queue entry.
// The result stage gives one beat per cycle unless the receiver stalls: most
// bytes make one beat or none, a message that ends the score two, a good header
// sixteen. Such bursts and receiver stalls can fill the queue and stall input.
// Reset is synchronous and active low; it needs no clearing pass.
module mus_score_to_midi_converter
    import msm_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_song_start,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_result_kind,
    output logic [7:0]  o_midi_status,
    output logic [6:0]  o_midi_data_one,
    output logic [6:0]  o_midi_data_two,
    output logic [31:0] o_delay_ticks,
    output logic        o_last_of_run,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // The single register, music volume, sits at byte addresses zero to three.
    logic [3:0] r_vol;
    logic       w_cfg_wr;

    logic       w_push;
    logic       w_pop;
    logic       w_full;
    logic       w_nonempty;
    t_cmd       w_cmd_in;
    t_cmd       w_cmd_out;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready && !paddr[2];
    assign prdata   = paddr[2] ? 32'd0 : {28'd0, r_vol};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vol <= 4'd8;
        end else if (w_cfg_wr) begin
            r_vol <= pwdata[3:0];
        end
    end

    // The front end parses bytes and classifies each into at most one queue entry.
    msm_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .i_data_byte    (i_data_byte),
        .i_song_start   (i_song_start),
        .i_music_volume (r_vol),
        .i_full         (w_full),
        .o_stall        (o_stall),
        .o_push         (w_push),
        .o_cmd          (w_cmd_in)
    );

    msm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_cmd      (w_cmd_in),
        .i_pop      (w_pop),
        .o_full     (w_full),
        .o_nonempty (w_nonempty),
        .o_cmd      (w_cmd_out)
    );

    // The back end expands each entry into output beats, finishing the
    // division by fifteen that the scaled velocities and volume values still need.
    msm_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_nonempty    (w_nonempty),
        .i_q_cmd         (w_cmd_out),
        .i_music_volume  (r_vol),
        .i_stall         (i_stall),
        .o_pop           (w_pop),
        .o_valid         (o_valid),
        .o_result_kind   (o_result_kind),
        .o_midi_status   (o_midi_status),
        .o_midi_data_one (o_midi_data_one),
        .o_midi_data_two (o_midi_data_two),
        .o_delay_ticks   (o_delay_ticks),
        .o_last_of_run   (o_last_of_run)
    );

`ifndef SYNTHESIS
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full)
        else $error("parser wrote into a full queue");

    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_result_kind == KIND_END || o_result_kind == KIND_BAD)
        |-> o_last_of_run)
        else $error("song end or bad header beat not last of its run");

    a_plain_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result_kind != KIND_MSG
        |-> o_midi_status == 8'd0 && o_midi_data_one == 7'd0 && o_midi_data_two == 7'd0)
        else $error("MIDI fields set on a non-message beat");

    a_ticks_only_delay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result_kind != KIND_DELAY |-> o_delay_ticks == 32'd0)
        else $error("tick count set on a non-delay beat");
`endif

endmodule

// ----- dv/mus_score_to_midi_converter_tb.sv -----
`timescale 1ns / 1ps

// Self-checking testbench for the MUS score to MIDI converter.
module mus_score_to_midi_converter_tb;
    import msm_pkg::*;

    // The random part stops once about this many bytes have been sent in all.
    localparam int ITEM_TARGET   = 250;
    // Cycles allowed for the command queue to empty after the last beat.
    localparam int SETTLE_CYCLES = 24;
    // Length of the long receiver hold-off that forces the queue to fill.
    localparam int HOLD_CYCLES   = 80;
    // A single byte never causes more beats than this.
    localparam int MAX_BEATS     = 16;

    localparam logic [2:0] REG_MUSIC_VOLUME = 3'd0;

    // MUS event types, taken from bits 6:4 of an event head byte.
    typedef enum logic [2:0] {
        MUS_REL    = 3'd0,
        MUS_PLAY   = 3'd1,
        MUS_BEND   = 3'd2,
        MUS_SYS    = 3'd3,
        MUS_CTRL   = 3'd4,
        MUS_END    = 3'd5,
        MUS_SPARE6 = 3'd6,
        MUS_SPARE7 = 3'd7
    } t_mus_ev;

    // Controller numbers with a special meaning in a MUS controller event.
    localparam logic [7:0] CTRL_PROGRAM = 8'd0;
    localparam logic [7:0] CTRL_VOLUME  = 8'd3;
    localparam logic [7:0] CTRL_TOP     = 8'd9;
    // System events that turn into MIDI controllers.
    localparam logic [7:0] SYS_LO       = 8'd10;
    localparam logic [7:0] SYS_HI       = 8'd14;

    // Where the parser model stands in the byte stream.
    typedef enum logic [2:0] {
        P_HDR, P_PAD, P_HEAD, P_DATA, P_VEL, P_VALUE, P_DELAY, P_OVER
    } t_parse_ph;

    typedef enum logic [1:0] {
        STALL_NONE, STALL_RANDOM, STALL_TOGGLE
    } t_stall_pat;

    typedef enum logic [1:0] {
        SHAPE_BAD_MAGIC, SHAPE_BAD_SIZE, SHAPE_GOOD
    } t_song_shape;

    localparam logic [7:0] MUS_MAGIC [4] = '{8'h4d, 8'h55, 8'h53, 8'h1a};
    localparam logic [3:0] CHAN_TAB [16] = '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
                                            4'd8, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15,
                                            4'd9};
    localparam logic [6:0] CTRL_TAB [15] = '{7'd0, 7'd0, 7'd1, 7'd7, 7'd10, 7'd11, 7'd91,
                                            7'd93, 7'd64, 7'd67, 7'd120, 7'd123, 7'd126,
                                            7'd127, 7'd121};

    // One beat on the output channel.
    typedef struct {
        t_kind       kind;
        logic [7:0]  status;
        logic [6:0]  d1;
        logic [6:0]  d2;
        logic [31:0] ticks;
        logic        last;
    } t_midi_beat;

    // One row of the directed table. Where known is set, the number of beats
    // the byte causes and the kind of the last one are given by hand.
    typedef struct packed {
        logic [7:0] data;
        logic       start;
        logic       known;
        t_kind      kind;
        logic [4:0] count;
    } t_dir_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [7:0]  i_data_byte = 8'd0;
    logic        i_song_start = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [1:0]  o_result_kind;
    logic [7:0]  o_midi_status;
    logic [6:0]  o_midi_data_one;
    logic [6:0]  o_midi_data_two;
    logic [31:0] o_delay_ticks;
    logic        o_last_of_run;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    mus_score_to_midi_converter u_dut (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Parser model: its own copy of the register and the parser state.
    // ------------------------------------------------------------------
    logic [3:0]  music_vol = 4'd8;
    t_parse_ph   ph;
    logic [16:0] pos;
    logic [15:0] start_ofs;
    logic [16:0] end_pos;
    t_mus_ev     ev_type;
    logic [3:0]  ev_chan;
    logic        ev_last;
    logic [7:0]  held;
    logic [6:0]  vel [16];
    logic [31:0] tick_acc;
    logic        magic_ok;

    t_midi_beat  step_beats [$];
    t_midi_beat  pending_midi [$];
    t_kind       step_last_kind;

    int mismatches = 0;
    int bytes_parsed = 0;
    int bytes_sent = 0;
    int beats_checked = 0;
    int songs = 0;
    int vol_writes = 0;
    int hold_requests = 0;
    int burst_left = 0;

    // The directed part: a file with a broken magic, then a well-formed file
    // with a note on that carries a zero velocity, a full pitch bend on MUS
    // channel 15, a volume controller with an overlong value that ends a
    // group, a two-byte delay and the score end marker.
    t_dir_row directed_rows [27] = '{
        '{8'h4d, 1'b1, 1'b1, KIND_MSG, 5'd0},
        '{8'h55, 1'b0, 1'b0, KIND_MSG, 5'd0},
        '{8'h53, 1'b0, 1'b0, KIND_MSG, 5'd0},
        '{8'h1b, 1'b0, 1'b0, KIND_MSG, 5'd0},
        '{8'h0b, 1'b0, 1'b0, KIND_MSG, 5'd0},
        '{8'h00, 1'b0, 1'b0, KIND_MSG, 5'd0},
        '{8'h08, 1'b0, 1'b0, KIND_MSG, 5'd0},
        '{8'h00, 1'b0, 1'b1, KIND_BAD, 5'd1},
        '{8'h4d, 1'b1, 1'b1, KIND_MSG, 5'd0},
        '{8'h55, 1'b0, 1'b0, KIND_MSG, 5'd0},
        '{8'h53, 1'b0, 1'b0, KIND_MSG, 5'd0},
        '{8'h1a, 1'b0, 1'b0, KIND_MSG, 5'd0},
        '{8'h0b, 1'b0, 1'b0, KIND_MSG, 5'd0},
        '{8'h00, 1'b0, 1'b0, KIND_MSG, 5'd0},
        '{8'h08, 1'b0, 1'b0, KIND_MSG, 5'd0},
        '{8'h00, 1'b0, 1'b1, KIND_MSG, 5'd16},
        '{8'h10, 1'b0, 1'b1, KIND_MSG, 5'd0},
        '{8'hff, 1'b0, 1'b1, KIND_MSG, 5'd0},
        '{8'h00, 1'b0, 1'b1, KIND_MSG, 5'd1},
        '{8'h2f, 1'b0, 1'b0, KIND_MSG, 5'd0},
        '{8'hff, 1'b0, 1'b0, KIND_MSG, 5'd0},
        '{8'hc3, 1'b0, 1'b0, KIND_MSG, 5'd0},
        '{8'h03, 1'b0, 1'b0, KIND_MSG, 5'd0},
        '{8'hff, 1'b0, 1'b0, KIND_MSG, 5'd0},
        '{8'hff, 1'b0, 1'b0, KIND_MSG, 5'd0},
        '{8'h7f, 1'b0, 1'b1, KIND_DELAY, 5'd1},
        '{8'h50, 1'b0, 1'b1, KIND_END, 5'd1}
    };

    function automatic void song_restart();
        ph = P_HDR;
        pos = '0;
        start_ofs = '0;
        end_pos = '0;
        ev_type = MUS_REL;
        ev_chan = '0;
        ev_last = 1'b0;
        held = '0;
        foreach (vel[c]) vel[c] = 7'd127;
        tick_acc = '0;
        magic_ok = 1'b1;
    endfunction

    function automatic void add_beat(input t_kind k, input logic [7:0] st,
                                     input logic [6:0] d1, input logic [6:0] d2,
                                     input logic [31:0] tk);
        t_midi_beat bt;
        if (step_beats.size() >= MAX_BEATS) return;
        bt.kind = k;
        bt.status = st;
        bt.d1 = d1;
        bt.d2 = d2;
        bt.ticks = tk;
        bt.last = 1'b0;
        step_beats.push_back(bt);
    endfunction

    // Value times music volume over fifteen, kept to seven bits.
    function automatic logic [6:0] vol_scale(input logic [7:0] v);
        logic [31:0] p;
        p = (32'(v) * 32'(music_vol)) / 32'd15;
        return p[6:0];
    endfunction

    // An event group either runs on to the next head or ends in a delay.
    function automatic void event_finished();
        if (ev_last) begin
            tick_acc = '0;
            ph = P_DELAY;
        end else begin
            ph = P_HEAD;
        end
    endfunction

    function automatic void header_step(input logic [7:0] b);
        logic [31:0] level;
        if (pos < 17'd4 && b != MUS_MAGIC[pos[1:0]]) magic_ok = 1'b0;
        case (pos)
            17'd4: end_pos = {9'd0, b};
            17'd5: end_pos[15:8] = b;
            17'd6: start_ofs = {8'd0, b};
            17'd7: begin
                start_ofs[15:8] = b;
                end_pos = end_pos + {1'b0, start_ofs};
                if (!magic_ok || end_pos < 17'd16 || {1'b0, start_ofs} >= end_pos ||
                    start_ofs < 16'd8) begin
                    add_beat(KIND_BAD, '0, '0, '0, '0);
                    ph = P_OVER;
                    return;
                end
                level = (32'd100 * 32'(music_vol)) / 32'd15;
                for (int c = 0; c < 16; c++)
                    add_beat(KIND_MSG, ST_CTRL | {4'd0, CHAN_TAB[c]}, CC_VOLUME, level[6:0], '0);
                ph = (start_ofs == 16'd8) ? P_HEAD : P_PAD;
            end
            default: ;
        endcase
        pos = pos + 17'd1;
    endfunction

    function automatic void score_step(input logic [7:0] b);
        logic [7:0]  mch;
        logic [13:0] bend;
        mch = {4'd0, CHAN_TAB[ev_chan]};
        case (ph)
            P_PAD: if (32'(pos) + 32'd1 >= 32'(start_ofs)) ph = P_HEAD;
            P_HEAD: begin
                ev_last = b[7];
                ev_type = t_mus_ev'(b[6:4]);
                ev_chan = b[3:0];
                if (ev_type == MUS_END) begin
                    add_beat(KIND_END, '0, '0, '0, '0);
                    ph = P_OVER;
                    return;
                end
                if (ev_type >= MUS_SPARE6) event_finished();
                else ph = P_DATA;
            end
            P_DATA: begin
                held = b;
                case (ev_type)
                    MUS_REL: begin
                        add_beat(KIND_MSG, ST_NOTE_OFF | mch, b[6:0], NOTE_OFF_VEL, '0);
                        event_finished();
                    end
                    MUS_PLAY: begin
                        // A set top bit means a fresh velocity byte follows.
                        if (b[7]) begin
                            ph = P_VEL;
                        end else begin
                            add_beat(KIND_MSG, ST_NOTE_ON | mch, b[6:0],
                                     vol_scale({1'b0, vel[ev_chan]}), '0);
                            event_finished();
                        end
                    end
                    MUS_BEND: begin
                        bend = {b, 6'd0};
                        add_beat(KIND_MSG, ST_BEND | mch, bend[6:0], bend[13:7], '0);
                        event_finished();
                    end
                    MUS_SYS: begin
                        if (b >= SYS_LO && b <= SYS_HI)
                            add_beat(KIND_MSG, ST_CTRL | mch, CTRL_TAB[b], '0, '0);
                        event_finished();
                    end
                    default: ph = P_VALUE;
                endcase
            end
            P_VEL: begin
                vel[ev_chan] = b[6:0];
                add_beat(KIND_MSG, ST_NOTE_ON | mch, held[6:0], vol_scale({1'b0, b[6:0]}), '0);
                event_finished();
            end
            P_VALUE: begin
                if (held == CTRL_PROGRAM)
                    add_beat(KIND_MSG, ST_PROGRAM | mch, b[6:0], '0, '0);
                else if (held <= CTRL_TOP)
                    add_beat(KIND_MSG, ST_CTRL | mch, CTRL_TAB[held],
                             (held == CTRL_VOLUME) ? vol_scale(b) : b[6:0], '0);
                event_finished();
            end
            P_DELAY: begin
                tick_acc = {tick_acc[24:0], b[6:0]};
                if (!b[7]) begin
                    add_beat(KIND_DELAY, '0, '0, '0, tick_acc);
                    ph = P_HEAD;
                end
            end
            default: return;
        endcase
        pos = pos + 17'd1;
        if (pos >= end_pos && ph != P_OVER) begin
            add_beat(KIND_END, '0, '0, '0, '0);
            ph = P_OVER;
        end
    endfunction

    // Takes one accepted byte, queues the beats it causes and returns their number.
    function automatic int mus_predict(input logic [7:0] b, input logic s);
        int n;
        step_beats.delete();
        if (s) song_restart();
        if (ph != P_OVER) bytes_parsed++;
        if (ph == P_HDR) header_step(b);
        else if (ph != P_OVER) score_step(b);
        n = step_beats.size();
        if (n > 0) begin
            step_beats[n - 1].last = 1'b1;
            step_last_kind = step_beats[n - 1].kind;
            foreach (step_beats[j]) pending_midi.push_back(step_beats[j]);
        end
        return n;
    endfunction

    // ------------------------------------------------------------------
    // Input side. Bytes go out in bursts of random length; between bursts
    // the sender may rest with valid low. A payload is held until the
    // block takes it, and the model sees the byte at that same edge.
    // ------------------------------------------------------------------
    task automatic feed_byte(input logic [7:0] b, input logic s, output int made);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                    : $urandom_range(1, 12);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        i_valid <= 1'b1;
        i_data_byte <= b;
        i_song_start <= s;
        do @(posedge i_clk); while (o_stall);
        made = mus_predict(b, s);
        bytes_sent++;
        burst_left--;
    endtask

    // Stops offering bytes until every predicted beat has been seen, then
    // gives any byte still inside the block time to leave it.
    task automatic wait_idle();
        i_valid <= 1'b0;
        burst_left = 0;
        while (pending_midi.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes the music volume over the register port and reads it back.
    task automatic set_music_volume(input logic [3:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= REG_MUSIC_VOLUME;
        pwdata <= {28'd0, v};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        music_vol = v;
        vol_writes++;
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata[3:0] !== v) begin
            $display("%0t: music_volume read back: expected %0d, actual %0d",
                     $realtime, v, prdata[3:0]);
            mismatches++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // Builds one MUS file with random events and sends it. Most files are
    // well formed; some carry a broken magic or impossible sizes, some are
    // cut short by a new song start, and some state a length that cuts the
    // last event off or runs well past the end marker. A file sent with
    // keep_good set has a good header and twelve events and is always sent whole.
    task automatic play_random_song(input bit keep_good);
        logic [7:0]  body [$];
        logic [7:0]  head [8];
        logic [7:0]  t;
        t_song_shape shape;
        t_mus_ev     ev;
        bit          last;
        int          r, n_ev, pad, len, start, k, hdr_count, body_count, made;
        r = $urandom_range(0, 9);
        shape = (keep_good || r >= 2) ? SHAPE_GOOD : (r == 0) ? SHAPE_BAD_MAGIC : SHAPE_BAD_SIZE;
        n_ev = keep_good ? 12 : $urandom_range(2, 12);
        for (int e = 0; e < n_ev; e++) begin
            case ($urandom_range(0, 11))
                0, 1:    ev = MUS_REL;
                2, 3, 4: ev = MUS_PLAY;
                5:       ev = MUS_BEND;
                6, 7:    ev = MUS_SYS;
                8, 9:    ev = MUS_CTRL;
                10:      ev = MUS_SPARE6;
                default: ev = MUS_SPARE7;
            endcase
            last = ($urandom_range(0, 2) == 0);
            body.push_back({last, ev, 4'($urandom_range(0, 15))});
            case (ev)
                MUS_REL, MUS_BEND: body.push_back(8'($urandom));
                MUS_PLAY: begin
                    t = 8'($urandom);
                    body.push_back(t);
                    if (t[7]) body.push_back(8'($urandom));
                end
                MUS_SYS: body.push_back(($urandom_range(0, 3) != 0) ?
                                        8'($urandom_range(SYS_LO, SYS_HI)) : 8'($urandom));
                MUS_CTRL: begin
                    body.push_back(($urandom_range(0, 4) != 0) ?
                                   8'($urandom_range(0, CTRL_TOP)) : 8'($urandom));
                    body.push_back(8'($urandom));
                end
                default: ;
            endcase
            if (last) begin
                // Now and then a delay long enough to wrap the tick count.
                k = ($urandom_range(0, 7) == 0) ? $urandom_range(3, 6) : $urandom_range(1, 2);
                repeat (k - 1) body.push_back(8'h80 | 8'($urandom_range(0, 127)));
                body.push_back(8'($urandom_range(0, 127)));
            end
        end
        if ($urandom_range(0, 1) == 1)
            body.push_back({1'($urandom), MUS_END, 4'($urandom_range(0, 15))});

        pad = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
        start = 8 + pad;
        len = body.size();
        r = $urandom_range(0, 9);
        if (r < 3) len = $urandom_range(len, 16'hffff);
        else if (r == 3) len = len - $urandom_range(1, (len > 3) ? 3 : 1);
        if (shape == SHAPE_BAD_SIZE) begin
            r = $urandom_range(0, 2);
            if (r == 0) begin
                start = $urandom_range(0, 7);
            end else if (r == 1) begin
                start = 8;
                len = $urandom_range(0, 7);
            end else begin
                start = $urandom_range(8, 16'hffff);
                len = 0;
            end
        end
        head = '{MUS_MAGIC[0], MUS_MAGIC[1], MUS_MAGIC[2], MUS_MAGIC[3],
                 8'(len), 8'(len >> 8), 8'(start), 8'(start >> 8)};
        if (shape == SHAPE_BAD_MAGIC) begin
            k = $urandom_range(0, 3);
            head[k] = head[k] ^ 8'($urandom_range(1, 255));
        end

        hdr_count = (!keep_good && $urandom_range(0, 19) == 0) ? $urandom_range(1, 7) : 8;
        if (shape != SHAPE_GOOD) body_count = $urandom_range(0, 3);
        else if (!keep_good && $urandom_range(0, 9) == 0)
            body_count = $urandom_range(0, body.size() - 1);
        else body_count = body.size();
        if (body_count > body.size()) body_count = body.size();

        for (int i = 0; i < hdr_count; i++) feed_byte(head[i], i == 0, made);
        if (hdr_count == 8) begin
            repeat (pad) feed_byte(8'($urandom), 1'b0, made);
            for (int i = 0; i < body_count; i++) feed_byte(body[i], 1'b0, made);
            repeat ($urandom_range(0, 2)) feed_byte(8'($urandom), 1'b0, made);
        end
    endtask

    // ------------------------------------------------------------------
    // Output side. The receiver switches between patterns of its own and,
    // on request, holds off for a long stretch so that the queue fills.
    // ------------------------------------------------------------------
    int         holds_served = 0;
    int         hold_left = 0;
    int         pat_left = 0;
    t_stall_pat stall_pat = STALL_NONE;

    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (holds_served != hold_requests) begin
            holds_served++;
            hold_left = HOLD_CYCLES - 1;
            i_stall <= 1'b1;
        end else begin
            if (pat_left == 0) begin
                stall_pat = t_stall_pat'($urandom_range(0, 2));
                pat_left = $urandom_range(20, 90);
            end else begin
                pat_left--;
            end
            case (stall_pat)
                STALL_NONE:   i_stall <= 1'b0;
                STALL_RANDOM: i_stall <= ($urandom_range(0, 99) < 40);
                default:      i_stall <= ~i_stall;
            endcase
        end
    end

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s: expected 0x%0h, actual 0x%0h", $realtime, what, want, got);
            mismatches++;
        end
    endtask

    // Each beat taken from the block is held against the oldest prediction.
    always @(posedge i_clk) begin
        t_midi_beat want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_midi.size() == 0) begin
                $display("%0t: beat with none expected: kind %0d status 0x%0h ticks %0d",
                         $realtime, o_result_kind, o_midi_status, o_delay_ticks);
                mismatches++;
            end else begin
                want = pending_midi.pop_front();
                beats_checked++;
                check_field("result_kind", 32'(want.kind), 32'(o_result_kind));
                check_field("midi_status", 32'(want.status), 32'(o_midi_status));
                check_field("midi_data_one", 32'(want.d1), 32'(o_midi_data_one));
                check_field("midi_data_two", 32'(want.d2), 32'(o_midi_data_two));
                check_field("delay_ticks", want.ticks, o_delay_ticks);
                check_field("last_of_run", 32'(want.last), 32'(o_last_of_run));
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence of the run.
    // ------------------------------------------------------------------
    initial begin
        t_dir_row row;
        int       made;
        song_restart();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // The directed table runs at the reset volume.
        for (int i = 0; i < $size(directed_rows); i++) begin
            row = directed_rows[i];
            feed_byte(row.data, row.start, made);
            if (row.known && (made != int'(row.count) ||
                              (made > 0 && step_last_kind != row.kind))) begin
                $display("%0t: byte %0d: expected %0d beats ending in %s, actual %0d ending in %s",
                         $realtime, i, row.count, row.kind.name(), made,
                         step_last_kind.name());
                mismatches++;
            end
        end

        // Random files. Every third file the volume changes while the block is
        // idle, through both extremes first. The second file is sent while the
        // receiver holds off, so the header burst backs up into the input.
        while (bytes_sent < ITEM_TARGET) begin
            if (songs % 3 == 0) begin
                wait_idle();
                set_music_volume((songs == 0) ? 4'd15 : (songs == 3) ? 4'd0
                                                      : 4'($urandom_range(0, 15)));
            end
            if (songs == 1) hold_requests++;
            play_random_song(songs == 1);
            songs++;
        end

        wait_idle();
        $display("Run covered %0d bytes sent, %0d of them live, in %0d random files",
                 bytes_sent, bytes_parsed, songs);
        $display("after the directed table, with %0d beats checked and %0d volume settings.",
                 beats_checked, vol_writes);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Guard against a hang: far beyond the slowest correct run.
    initial begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

endmodule

// ----- mus_score_to_midi_converter.f -----
design/msm_pkg.sv
design/msm_front.sv
design/msm_queue.sv
design/msm_back.sv
design/mus_score_to_midi_converter.sv
dv/mus_score_to_midi_converter_tb.sv
